// ===== rtl/core/ifhb_pkg.sv =====
// ----------------------------------------------------------------------------
// ifhb_pkg
// Shared constants, the checksum adder and the controller/datapath interface
// types for the IPv4 fragment header builder.
// ----------------------------------------------------------------------------
package ifhb_pkg;

	localparam int unsigned LEN_W     = 16;
	localparam int unsigned ADDR_W    = 32;
	localparam int unsigned PROTO_W   = 8;
	localparam int unsigned OUT_LEN_W = 11;
	localparam int unsigned OFF8_W    = 13;

	localparam logic [LEN_W-1:0] HDR_BYTES   = 16'd20;
	localparam logic [7:0]       HDR_TTL     = 8'd64;
	localparam logic [3:0]       HDR_VER     = 4'd4;
	localparam logic [3:0]       HDR_IHL     = 4'd5;
	localparam logic [15:0]      VER_IHL_WORD = {HDR_VER, HDR_IHL, 8'h00};

	// Header words that do not change between fragments of one packet
	localparam int unsigned      BASE_WORDS = 7;
	localparam int unsigned      STEP_W     = $clog2(BASE_WORDS);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(BASE_WORDS - 1);

	localparam int unsigned       RESULT_LIMIT = 45;
	localparam int unsigned       CNT_W        = $clog2(RESULT_LIMIT);
	localparam logic [CNT_W-1:0]  CNT_LAST     = CNT_W'(RESULT_LIMIT - 1);

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;       // take a request, clear the walk
		logic base_add;   // add one fixed header word
		logic size;       // cut the next chunk
		logic sum_len;    // add the total length word
		logic sum_flags;  // add the flags/offset word
		logic emit;       // load the output register, advance the walk
	} ifhb_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic base_last;  // final fixed word being added
		logic out_free;   // output register can take a descriptor
		logic frag_last;  // current fragment closes the packet
	} ifhb_sts_t;

	// Ones'-complement add of two 16-bit words with end-around carry
	function automatic logic [15:0] csum_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + {15'd0, s[16]};
	endfunction

endpackage

// ===== rtl/core/ifhb_ctrl.sv =====
// ----------------------------------------------------------------------------
// ifhb_ctrl
// Sequencer: takes a request, steps the fixed-word sum, then walks the
// fragments four steps each until the last descriptor is handed over.
// ----------------------------------------------------------------------------
module ifhb_ctrl
	import ifhb_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  ifhb_sts_t sts,
	output ifhb_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BASE,
		ST_SIZE,
		ST_LEN,
		ST_FLAGS,
		ST_EMIT
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd           = '0;
		cmd.load      = (state_q == ST_IDLE) && in_valid;
		cmd.base_add  = (state_q == ST_BASE);
		cmd.size      = (state_q == ST_SIZE);
		cmd.sum_len   = (state_q == ST_LEN);
		cmd.sum_flags = (state_q == ST_FLAGS);
		cmd.emit      = (state_q == ST_EMIT) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_BASE;
				end
				ST_BASE: begin
					if (sts.base_last) state_q <= ST_SIZE;
				end
				ST_SIZE:  state_q <= ST_LEN;
				ST_LEN:   state_q <= ST_FLAGS;
				ST_FLAGS: state_q <= ST_EMIT;
				ST_EMIT: begin
					// hold until the output register frees up
					if (sts.out_free) state_q <= sts.frag_last ? ST_IDLE : ST_SIZE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/core/ifhb_dp.sv =====
// ----------------------------------------------------------------------------
// ifhb_dp
// Datapath: request and walk registers, identification counter, source
// address register, ones'-complement checksum adders and the descriptor output register.
// ----------------------------------------------------------------------------
module ifhb_dp
	import ifhb_pkg::*;
#(
	parameter int unsigned MAX_FRAGMENT_PAYLOAD = 1480
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ifhb_cmd_t            cmd,
	output ifhb_sts_t            sts,
	input  logic                 cfg_we,
	input  logic [ADDR_W-1:0]    cfg_data,
	input  logic [LEN_W-1:0]     payload_length,
	input  logic [ADDR_W-1:0]    destination_address,
	input  logic [PROTO_W-1:0]   protocol,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [OUT_LEN_W-1:0] total_length,
	output logic [15:0]          identification,
	output logic [OFF8_W-1:0]    offset_units,
	output logic                 more_fragments,
	output logic [PROTO_W-1:0]   echo_protocol,
	output logic [ADDR_W-1:0]    echo_destination,
	output logic [15:0]          header_checksum,
	output logic [LEN_W-1:0]     payload_start,
	output logic [OUT_LEN_W-1:0] fragment_bytes,
	output logic                 last_fragment
);

	localparam logic [LEN_W-1:0] CHUNK = LEN_W'(MAX_FRAGMENT_PAYLOAD);

	// control state
	logic [15:0]       id_cnt_q;
	logic [ADDR_W-1:0] local_q;
	logic              out_valid_q;

	// working registers
	logic [ADDR_W-1:0]  dst_q;
	logic [PROTO_W-1:0] proto_q;
	logic [15:0]        id_q;
	logic [LEN_W-1:0]   remain_q;
	logic [LEN_W-1:0]   offset_q;
	logic [LEN_W-1:0]   flen_q;
	logic               mf_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [STEP_W-1:0]  step_q;
	logic [15:0]        base_q;
	logic [15:0]        acc_q;

	// output register
	logic [OUT_LEN_W-1:0] tlen_o_q;
	logic [15:0]          id_o_q;
	logic [OFF8_W-1:0]    off8_o_q;
	logic                 mf_o_q;
	logic [PROTO_W-1:0]   proto_o_q;
	logic [ADDR_W-1:0]    dst_o_q;
	logic [15:0]          csum_o_q;
	logic [LEN_W-1:0]     start_o_q;
	logic [OUT_LEN_W-1:0] flen_o_q;
	logic                 last_o_q;

	logic [15:0]      base_word;
	logic [LEN_W-1:0] tlen;
	logic [15:0]      flags_word;
	logic             out_free;

	always_comb begin
		case (step_q)
			3'd0:    base_word = VER_IHL_WORD;
			3'd1:    base_word = id_q;
			3'd2:    base_word = {HDR_TTL, proto_q};
			3'd3:    base_word = local_q[31:16];
			3'd4:    base_word = local_q[15:0];
			3'd5:    base_word = dst_q[31:16];
			3'd6:    base_word = dst_q[15:0];
			default: base_word = 16'h0000;
		endcase
	end

	assign tlen       = flen_q + HDR_BYTES;
	assign flags_word = {2'b00, mf_q, offset_q[LEN_W-1:3]};
	assign out_free   = !out_valid_q || out_ready;

	assign sts.base_last = (step_q == STEP_LAST);
	assign sts.out_free  = out_free;
	assign sts.frag_last = !mf_q || (cnt_q == CNT_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_cnt_q    <= '0;
			local_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) local_q <= cfg_data;
			if (cmd.load) id_cnt_q <= id_cnt_q + 16'd1;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dst_q    <= destination_address;
			proto_q  <= protocol;
			id_q     <= id_cnt_q;
			remain_q <= payload_length;
			offset_q <= '0;
			cnt_q    <= '0;
			step_q   <= '0;
			base_q   <= '0;
		end
		if (cmd.base_add) begin
			base_q <= csum_add(base_q, base_word);
			step_q <= step_q + STEP_W'(1);
		end
		if (cmd.size) begin
			flen_q <= (remain_q > CHUNK) ? CHUNK : remain_q;
			mf_q   <= (remain_q > CHUNK);
		end
		if (cmd.sum_len)   acc_q <= csum_add(base_q, tlen);
		if (cmd.sum_flags) acc_q <= csum_add(acc_q, flags_word);
		if (cmd.emit) begin
			tlen_o_q  <= tlen[OUT_LEN_W-1:0];
			id_o_q    <= id_q;
			off8_o_q  <= offset_q[LEN_W-1:3];
			mf_o_q    <= mf_q;
			proto_o_q <= proto_q;
			dst_o_q   <= dst_q;
			csum_o_q  <= ~acc_q;
			start_o_q <= offset_q;
			flen_o_q  <= flen_q[OUT_LEN_W-1:0];
			last_o_q  <= !mf_q || (cnt_q == CNT_LAST);
			offset_q  <= offset_q + flen_q;
			remain_q  <= remain_q - flen_q;
			cnt_q     <= cnt_q + CNT_W'(1);
		end
	end

	assign out_valid        = out_valid_q;
	assign total_length     = tlen_o_q;
	assign identification   = id_o_q;
	assign offset_units     = off8_o_q;
	assign more_fragments   = mf_o_q;
	assign echo_protocol    = proto_o_q;
	assign echo_destination = dst_o_q;
	assign header_checksum  = csum_o_q;
	assign payload_start    = start_o_q;
	assign fragment_bytes   = flen_o_q;
	assign last_fragment    = last_o_q;

endmodule

// ===== rtl/core/ipv4_fragment_header_builder_unit.sv =====
// ----------------------------------------------------------------------------
// ipv4_fragment_header_builder_unit
// Turns one send request into a run of IPv4 header descriptors, one per
// fragment, each with its own header checksum.
// ----------------------------------------------------------------------------
// Each input beat (payload length, destination, protocol) produces one output
// beat per fragment, in order, with the last one flagged by last_fragment.
// Payloads longer than MAX_FRAGMENT_PAYLOAD are cut into chunks of that size
// plus a tail of at most that size; an empty payload still gives one 20-byte header. All
// fragments share an identification taken from a 16-bit counter that resets
// to zero and advances once per request. At most 45 descriptors come out per
// request; should more chunks be needed, drop the rest and flag the 45th as
// last while its more_fragments bit stays set. A request is accepted, the
// seven fixed header words (version, identification, TTL/protocol, source
// and destination) are summed in turn through the ones'-complement adder,
// then each fragment is cut, gets its total length and flags/offset words
// added and is handed over; the hand-over waits while the output register
// is full. A new request is taken once the last descriptor of the previous
// one sits in the output register, so the next request's fixed-word sum
// overlaps the wait for that beat to be taken. local_address is written
// through the cfg channel, which is always ready; write it only while the
// block is idle.
// ----------------------------------------------------------------------------
module ipv4_fragment_header_builder_unit
	import ifhb_pkg::*;
#(
	parameter int unsigned MAX_FRAGMENT_PAYLOAD = 1480
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [ADDR_W-1:0]    cfg_data,
	// request channel
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [LEN_W-1:0]     payload_length,
	input  logic [ADDR_W-1:0]    destination_address,
	input  logic [PROTO_W-1:0]   protocol,
	// descriptor channel
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [OUT_LEN_W-1:0] total_length,
	output logic [15:0]          identification,
	output logic [OFF8_W-1:0]    offset_units,
	output logic                 more_fragments,
	output logic [PROTO_W-1:0]   echo_protocol,
	output logic [ADDR_W-1:0]    echo_destination,
	output logic [15:0]          header_checksum,
	output logic [LEN_W-1:0]     payload_start,
	output logic [OUT_LEN_W-1:0] fragment_bytes,
	output logic                 last_fragment
);

	ifhb_cmd_t cmd;
	ifhb_sts_t sts;

	// the register write never stalls
	assign cfg_ready = 1'b1;

	ifhb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ifhb_dp #(
		.MAX_FRAGMENT_PAYLOAD (MAX_FRAGMENT_PAYLOAD)
	) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.sts                 (sts),
		.cfg_we              (cfg_valid && cfg_ready),
		.cfg_data            (cfg_data),
		.payload_length      (payload_length),
		.destination_address (destination_address),
		.protocol            (protocol),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.total_length        (total_length),
		.identification      (identification),
		.offset_units        (offset_units),
		.more_fragments      (more_fragments),
		.echo_protocol       (echo_protocol),
		.echo_destination    (echo_destination),
		.header_checksum     (header_checksum),
		.payload_start       (payload_start),
		.fragment_bytes      (fragment_bytes),
		.last_fragment       (last_fragment)
	);

endmodule

// ===== test/ifhb_descriptor_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifhb_descriptor_checker
// Watches the configuration, request and descriptor channels of the IPv4
// fragment header builder. Builds the expected header descriptors for every
// accepted request and compares every accepted descriptor with them, field
// by field.
// ----------------------------------------------------------------------------
module ifhb_descriptor_checker
	import ifhb_pkg::*;
#(
	parameter int unsigned FRAG_PAYLOAD_MAX = 1480
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [ADDR_W-1:0]    cfg_data,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [LEN_W-1:0]     payload_length,
	input  logic [ADDR_W-1:0]    destination_address,
	input  logic [PROTO_W-1:0]   protocol,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [OUT_LEN_W-1:0] total_length,
	input  logic [15:0]          identification,
	input  logic [OFF8_W-1:0]    offset_units,
	input  logic                 more_fragments,
	input  logic [PROTO_W-1:0]   echo_protocol,
	input  logic [ADDR_W-1:0]    echo_destination,
	input  logic [15:0]          header_checksum,
	input  logic [LEN_W-1:0]     payload_start,
	input  logic [OUT_LEN_W-1:0] fragment_bytes,
	input  logic                 last_fragment,
	output int unsigned          mismatch_count,
	output int unsigned          expected_count
);

	localparam int unsigned FRAGMENT_CAP = 45;
	localparam int unsigned IP_HDR_BYTES = 20;
	localparam logic [15:0] VER_IHL_TOS  = 16'h4500;
	localparam logic [7:0]  IP_TTL       = 8'd64;

	typedef struct packed {
		logic [OUT_LEN_W-1:0] total_length;
		logic [15:0]          identification;
		logic [OFF8_W-1:0]    offset_units;
		logic                 more_fragments;
		logic [PROTO_W-1:0]   echo_protocol;
		logic [ADDR_W-1:0]    echo_destination;
		logic [15:0]          header_checksum;
		logic [LEN_W-1:0]     payload_start;
		logic [OUT_LEN_W-1:0] fragment_bytes;
		logic                 last_fragment;
	} frag_desc_t;

	frag_desc_t  descriptor_q[$];
	logic [31:0] source_address;
	logic [15:0] packet_id;
	int unsigned errors;

	// Internet checksum over the ten header words, checksum word taken as zero
	function automatic logic [15:0] ip_header_checksum(input logic [15:0] tlen,
			input logic [15:0] id, input logic [15:0] flags_off, input logic [7:0] proto,
			input logic [31:0] src, input logic [31:0] dst);
		logic [31:0] acc;
		acc = 32'(VER_IHL_TOS) + 32'(tlen) + 32'(id) + 32'(flags_off)
			+ 32'({IP_TTL, proto}) + 32'(src[31:16]) + 32'(src[15:0])
			+ 32'(dst[31:16]) + 32'(dst[15:0]);
		acc = 32'(acc[15:0]) + 32'(acc[31:16]);
		acc = 32'(acc[15:0]) + 32'(acc[31:16]);
		return ~acc[15:0];
	endfunction

	// Cut one request into fragments and queue the descriptors it should give
	function automatic void queue_fragment_headers(input logic [15:0] plen,
			input logic [31:0] dst, input logic [7:0] proto);
		int unsigned remain;
		int unsigned offset;
		int unsigned flen;
		int unsigned emitted;
		logic        mf;
		logic [15:0] tlen;
		frag_desc_t  d;
		remain  = plen;
		offset  = 0;
		emitted = 0;
		do begin
			flen = (remain > FRAG_PAYLOAD_MAX) ? FRAG_PAYLOAD_MAX : remain;
			mf   = remain > flen;
			tlen = 16'(flen + IP_HDR_BYTES);
			d.total_length     = tlen[OUT_LEN_W-1:0];
			d.identification   = packet_id;
			d.offset_units     = OFF8_W'(offset / 8);
			d.more_fragments   = mf;
			d.echo_protocol    = proto;
			d.echo_destination = dst;
			d.header_checksum  = ip_header_checksum(tlen, packet_id,
				{2'b00, mf, OFF8_W'(offset / 8)}, proto, source_address, dst);
			d.payload_start    = 16'(offset);
			d.fragment_bytes   = OUT_LEN_W'(flen);
			d.last_fragment    = !mf;
			emitted++;
			offset += flen;
			remain -= flen;
			// past the cap, drop the rest and close the packet on this one
			if (remain != 0 && emitted == FRAGMENT_CAP)
				d.last_fragment = 1'b1;
			descriptor_q.push_back(d);
		end while (remain != 0 && emitted < FRAGMENT_CAP && FRAG_PAYLOAD_MAX != 0);
		packet_id = packet_id + 16'd1;
	endfunction

	task automatic check_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		frag_desc_t exp_d;
		if (!arst_n) begin
			descriptor_q.delete();
			source_address = '0;
			packet_id      = '0;
			errors         = 0;
			mismatch_count <= 0;
			expected_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				source_address = cfg_data;
			if (out_valid && out_ready) begin
				if (descriptor_q.size() == 0) begin
					$display("%0t ns: descriptor beat with none outstanding, actual id %0h start %0h",
						$time, identification, payload_start);
					errors++;
				end else begin
					exp_d = descriptor_q.pop_front();
					check_field("total_length", 32'(exp_d.total_length), 32'(total_length));
					check_field("identification", 32'(exp_d.identification),
						32'(identification));
					check_field("offset_units", 32'(exp_d.offset_units),
						32'(offset_units));
					check_field("more_fragments", 32'(exp_d.more_fragments),
						32'(more_fragments));
					check_field("echo_protocol", 32'(exp_d.echo_protocol), 32'(echo_protocol));
					check_field("echo_destination", exp_d.echo_destination, echo_destination);
					check_field("header_checksum", 32'(exp_d.header_checksum),
						32'(header_checksum));
					check_field("payload_start", 32'(exp_d.payload_start), 32'(payload_start));
					check_field("fragment_bytes", 32'(exp_d.fragment_bytes),
						32'(fragment_bytes));
					check_field("last_fragment", 32'(exp_d.last_fragment), 32'(last_fragment));
				end
			end
			if (in_valid && in_ready)
				queue_fragment_headers(payload_length, destination_address, protocol);
			mismatch_count <= errors;
			expected_count <= descriptor_q.size();
		end
	end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the IPv4 fragment header builder.
// ----------------------------------------------------------------------------
// Sends a directed set of packet requests (empty, single-fragment and
// boundary payload sizes, extreme addresses and protocols) followed by
// phases of random requests, reprogramming the source address between
// phases while the block is idle. Both the request and descriptor sides
// idle in random bursts except in the last phase. A checker beside the
// block predicts every descriptor and reports mismatches; this module only
// drives stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
	import ifhb_pkg::*;

	localparam int unsigned FRAG_PAYLOAD    = 1480;
	localparam int unsigned PAYLOAD_LEN_MAX = 65515;
	// settle time after the last descriptor before touching config or ending
	localparam int unsigned SETTLE_CYCLES   = 24;
	localparam int unsigned DIRECTED_ITEMS  = 20;

	logic                 clk    = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [ADDR_W-1:0]    cfg_data  = '0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	logic [LEN_W-1:0]     payload_length      = '0;
	logic [ADDR_W-1:0]    destination_address = '0;
	logic [PROTO_W-1:0]   protocol            = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [OUT_LEN_W-1:0] total_length;
	logic [15:0]          identification;
	logic [OFF8_W-1:0]    offset_units;
	logic                 more_fragments;
	logic [PROTO_W-1:0]   echo_protocol;
	logic [ADDR_W-1:0]    echo_destination;
	logic [15:0]          header_checksum;
	logic [LEN_W-1:0]     payload_start;
	logic [OUT_LEN_W-1:0] fragment_bytes;
	logic                 last_fragment;

	int unsigned mismatch_count;
	int unsigned expected_count;
	// cleared for the final phase so that it runs with no idling at all
	bit          allow_idle = 1'b1;

	ipv4_fragment_header_builder_unit #(
		.MAX_FRAGMENT_PAYLOAD(FRAG_PAYLOAD)
	) u_dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_valid           (cfg_valid),
		.cfg_ready           (cfg_ready),
		.cfg_data            (cfg_data),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.payload_length      (payload_length),
		.destination_address (destination_address),
		.protocol            (protocol),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.total_length        (total_length),
		.identification      (identification),
		.offset_units        (offset_units),
		.more_fragments      (more_fragments),
		.echo_protocol       (echo_protocol),
		.echo_destination    (echo_destination),
		.header_checksum     (header_checksum),
		.payload_start       (payload_start),
		.fragment_bytes      (fragment_bytes),
		.last_fragment       (last_fragment)
	);

	ifhb_descriptor_checker #(
		.FRAG_PAYLOAD_MAX(FRAG_PAYLOAD)
	) u_checker (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_valid           (cfg_valid),
		.cfg_ready           (cfg_ready),
		.cfg_data            (cfg_data),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.payload_length      (payload_length),
		.destination_address (destination_address),
		.protocol            (protocol),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.total_length        (total_length),
		.identification      (identification),
		.offset_units        (offset_units),
		.more_fragments      (more_fragments),
		.echo_protocol       (echo_protocol),
		.echo_destination    (echo_destination),
		.header_checksum     (header_checksum),
		.payload_start       (payload_start),
		.fragment_bytes      (fragment_bytes),
		.last_fragment       (last_fragment),
		.mismatch_count      (mismatch_count),
		.expected_count      (expected_count)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Descriptor side: ready in runs of random length, broken by stall bursts
	// while idling is allowed. Some runs skip the stall so that stretches of
	// uninterrupted flow occur in every phase.
	initial begin
		forever begin
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 40)) @(posedge clk);
			if (allow_idle && $urandom_range(0, 4) != 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
		end
	end

	// Write the source address; only called with nothing in flight.
	task automatic write_local_address(input logic [31:0] addr);
		cfg_valid <= 1'b1;
		cfg_data  <= addr;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Present one request and hold it until the block takes the beat. Valid
	// stays high across back-to-back requests; drop it only for a gap.
	task automatic send_request(input logic [15:0] plen, input logic [31:0] dst,
			input logic [7:0] proto);
		if (allow_idle && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid            <= 1'b1;
		payload_length      <= plen;
		destination_address <= dst;
		protocol            <= proto;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Release the request channel, wait for every outstanding descriptor,
	// then let the block settle before a register write or the verdict.
	task automatic drain_descriptors();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_count != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Random requests. Payload sizes are skewed: many single-fragment and
	// few-fragment packets, sizes either side of fragment boundaries, and a
	// share of near-maximal packets that run up to the 45-descriptor case.
	task automatic run_random(input int unsigned count);
		logic [15:0] plen;
		logic [31:0] dst;
		logic [7:0]  proto;
		int unsigned k;
		repeat (count) begin
			case ($urandom_range(0, 9))
				0, 1: plen = 16'($urandom_range(0, FRAG_PAYLOAD));
				2: plen = 16'($urandom_range(0, 64));
				3: begin
					k    = $urandom_range(1, 44);
					plen = 16'(k * FRAG_PAYLOAD + $urandom_range(0, 2) - 1);
				end
				4: plen = 16'($urandom_range(0, PAYLOAD_LEN_MAX));
				5: plen = 16'($urandom_range(60000, PAYLOAD_LEN_MAX));
				default: plen = 16'($urandom_range(FRAG_PAYLOAD + 1, 8000));
			endcase
			case ($urandom_range(0, 7))
				0: dst = 32'h0000_0000;
				1: dst = 32'hFFFF_FFFF;
				default: dst = $urandom;
			endcase
			case ($urandom_range(0, 7))
				0: proto = 8'd0;
				1: proto = 8'hFF;
				default: proto = 8'($urandom);
			endcase
			send_request(plen, dst, proto);
		end
	endtask

	// Hard stop well beyond the slowest legal run (every request at 45
	// descriptors, every beat behind the longest stall).
	initial begin
		#(20_000_000);
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		// Directed payload sizes: empty, tiny, around the 8-byte offset unit,
		// around one, two, three and forty-four fragment boundaries, the upper bit of the
		// length field, and the largest lengths that leave room for the 20-byte header.
		int unsigned dir_len [DIRECTED_ITEMS] = '{
			0, 1, 7, 8, 9, 1479, 1480, 1481, 2959, 2960,
			2961, 4440, 32768, 40000, 65119, 65120, 65121, 65513, 65514, 65515
		};
		logic [31:0] dir_dst;
		logic [7:0]  dir_proto;

		// hold reset from time zero, then release it for good
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed phase with every source address bit set, so the checksum
		// sum has end-around carries to fold.
		write_local_address(32'hFFFF_FFFF);
		for (int i = 0; i < DIRECTED_ITEMS; i++) begin
			case (i % 3)
				0: dir_dst = 32'h0000_0000;
				1: dir_dst = 32'hFFFF_FFFF;
				default: dir_dst = $urandom;
			endcase
			case (i % 4)
				0: dir_proto = 8'd0;
				1: dir_proto = 8'hFF;
				2: dir_proto = 8'd6;
				default: dir_proto = 8'd17;
			endcase
			send_request(16'(dir_len[i]), dir_dst, dir_proto);
		end
		drain_descriptors();

		// Random phases under different source addresses, all-zero first.
		write_local_address(32'h0000_0000);
		run_random(120);
		drain_descriptors();

		write_local_address($urandom);
		run_random(130);
		drain_descriptors();

		write_local_address(32'h8000_0001);
		run_random(130);
		drain_descriptors();

		// Final phase: no idling on either side, full back-to-back flow.
		write_local_address($urandom);
		allow_idle = 1'b0;
		run_random(120);
		drain_descriptors();

		if (mismatch_count == 0 && expected_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== ipv4_fragment_header_builder_unit.f =====
rtl/core/ifhb_pkg.sv
rtl/core/ifhb_ctrl.sv
rtl/core/ifhb_dp.sv
rtl/core/ipv4_fragment_header_builder_unit.sv
test/ifhb_descriptor_checker.sv
test/tb_top.sv
